[rtl/msm_pkg.sv]
// ----------------------------------------------------------------------------
// msm_pkg
// Shared types and constants for the microcoded stack machine datapath.
// ----------------------------------------------------------------------------
package msm_pkg;

    // main memory geometry, four byte lanes per row (MEM_BYTES is a power of two)
    localparam int MEM_BYTES = 65536;
    localparam int ADDR_W    = $clog2(MEM_BYTES);
    localparam int ROW_W     = ADDR_W - 2;
    localparam int MEM_ROWS  = MEM_BYTES / 4;

    localparam int NUM_REGS = 9;

    // register file indexes
    localparam logic [3:0] R_MAR = 4'd0;
    localparam logic [3:0] R_MDR = 4'd1;
    localparam logic [3:0] R_PC  = 4'd2;
    localparam logic [3:0] R_SP  = 4'd3;
    localparam logic [3:0] R_LV  = 4'd4;
    localparam logic [3:0] R_CPP = 4'd5;
    localparam logic [3:0] R_TOS = 4'd6;
    localparam logic [3:0] R_OPC = 4'd7;
    localparam logic [3:0] R_H   = 4'd8;

    // item opcodes
    localparam logic OP_EXEC = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // B bus sources
    localparam logic [3:0] B_MDR  = 4'd0;
    localparam logic [3:0] B_PC   = 4'd1;
    localparam logic [3:0] B_MBRU = 4'd2;
    localparam logic [3:0] B_MBR  = 4'd3;
    localparam logic [3:0] B_SP   = 4'd4;
    localparam logic [3:0] B_LV   = 4'd5;
    localparam logic [3:0] B_CPP  = 4'd6;
    localparam logic [3:0] B_TOS  = 4'd7;
    localparam logic [3:0] B_OPC  = 4'd8;

    // ALU functions
    localparam logic [5:0] ALU_AND    = 6'd12;
    localparam logic [5:0] ALU_ZERO   = 6'd16;
    localparam logic [5:0] ALU_B      = 6'd20;
    localparam logic [5:0] ALU_A      = 6'd24;
    localparam logic [5:0] ALU_NOTA   = 6'd26;
    localparam logic [5:0] ALU_OR     = 6'd28;
    localparam logic [5:0] ALU_NOTB   = 6'd44;
    localparam logic [5:0] ALU_ONE    = 6'd49;
    localparam logic [5:0] ALU_ONES   = 6'd50;
    localparam logic [5:0] ALU_BINC   = 6'd53;
    localparam logic [5:0] ALU_BDEC   = 6'd54;
    localparam logic [5:0] ALU_AINC   = 6'd57;
    localparam logic [5:0] ALU_NEGA   = 6'd59;
    localparam logic [5:0] ALU_ADD    = 6'd60;
    localparam logic [5:0] ALU_ADDINC = 6'd61;
    localparam logic [5:0] ALU_BSUBA  = 6'd63;

    // shifter
    localparam logic [1:0] SH_NONE   = 2'd0;
    localparam logic [1:0] SH_SRA1   = 2'd1;
    localparam logic [1:0] SH_SLL8   = 2'd2;
    localparam logic [1:0] SH_BOTH   = 2'd3;

    // memory operations
    localparam logic [2:0] MEM_FETCH = 3'd1;
    localparam logic [2:0] MEM_READ  = 3'd2;
    localparam logic [2:0] MEM_WRITE = 3'd4;

    // jam modes
    localparam logic [2:0] JAM_NONE = 3'd0;
    localparam logic [2:0] JAM_Z    = 3'd1;
    localparam logic [2:0] JAM_NZ   = 3'd2;
    localparam logic [2:0] JAM_KEEP = 3'd3;
    localparam logic [2:0] JAM_MBR  = 3'd4;

    // pending read kind carried into the second stage
    localparam logic [1:0] RD_NONE  = 2'd0;
    localparam logic [1:0] RD_FETCH = 2'd1;
    localparam logic [1:0] RD_WORD  = 2'd2;

    typedef struct packed {
        logic        opcode;
        logic [35:0] microinstruction;
        logic [15:0] load_address;
        logic [7:0]  load_byte;
    } cmd_t;

    typedef struct packed {
        logic [8:0]  next_address;
        logic [31:0] c_bus;
        logic        zero_flag;
        logic        nonzero_flag;
        logic [7:0]  fetched_byte;
        logic [31:0] top_of_stack;
    } rsp_t;

    // snapshot handed from the execute stage to the completion stage
    typedef struct packed {
        logic [1:0]  rd;
        logic [1:0]  lane;
        logic [2:0]  jam;
        logic [8:0]  nxt;
        logic        z;
        logic        nz;
        logic [31:0] c;
        logic [31:0] tos;
    } stage_t;

endpackage

[rtl/microcoded_stack_machine_datapath.sv]
// ----------------------------------------------------------------------------
// microcoded_stack_machine_datapath
// An item passes through s2_reg and then the output register rsp_reg.
// Throughput: one item per cycle while the output is not stalled; an item
// that fetches a byte or reads a word holds the next transfer back until it
// completes, as registered RAM read data feeds MBR/MDR to the execute stage.
// Reset: registers, MBR, flags, bus holds and counter clear at once; main
// memory is not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
module microcoded_stack_machine_datapath (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  msm_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output msm_pkg::rsp_t rsp
);

    // ------------------------------------------------------------------
    // Architectural state
    // ------------------------------------------------------------------
    logic [31:0] regs_reg [msm_pkg::NUM_REGS];
    logic [31:0] regs_next [msm_pkg::NUM_REGS];
    logic [7:0]  mbr_reg;
    logic [7:0]  mbr_next;
    logic [8:0]  counter_reg;
    logic [8:0]  counter_next;
    logic        flag_z_reg;
    logic        flag_nz_reg;
    logic [31:0] b_hold_reg;
    logic [31:0] c_hold_reg;

    // pipeline
    logic            s2_valid_reg;
    msm_pkg::stage_t s2_reg;
    msm_pkg::stage_t s2_next;
    logic            rsp_valid_reg;
    msm_pkg::rsp_t   rsp_reg;

    // registered main memory read data of the access
    logic [31:0]     ram_rdata;

    // ------------------------------------------------------------------
    // Handshake
    // A read result lands in MBR/MDR only at the end of the second stage,
    // so no new item enters while a read is pending there.
    // ------------------------------------------------------------------
    logic out_ready;
    logic s2_adv;
    logic accept;
    logic exec;

    assign out_ready = !rsp_valid_reg || !rsp_stall;
    assign s2_adv    = s2_valid_reg && out_ready;
    assign cmd_stall = s2_valid_reg && ((s2_reg.rd != msm_pkg::RD_NONE) || !out_ready);
    assign accept    = cmd_valid && !cmd_stall;
    assign exec      = accept && (cmd.opcode == msm_pkg::OP_EXEC);

    // microinstruction fields
    logic [3:0] bsrc;
    logic [2:0] mem_op;
    logic [8:0] wmask;
    logic [1:0] shift;
    logic [5:0] alu_fn;
    logic [2:0] jam;
    logic [8:0] nxt;

    assign bsrc   = cmd.microinstruction[3:0];
    assign mem_op = cmd.microinstruction[6:4];
    assign wmask  = cmd.microinstruction[15:7];
    assign alu_fn = cmd.microinstruction[21:16];
    assign shift  = cmd.microinstruction[23:22];
    assign jam    = cmd.microinstruction[26:24];
    assign nxt    = cmd.microinstruction[35:27];

    // ------------------------------------------------------------------
    // Execute stage: B bus, ALU, shifter, register write
    // ------------------------------------------------------------------
    logic [31:0] b_val;
    logic [31:0] a_val;
    logic [31:0] alu_out;
    logic [31:0] sll8;
    logic [31:0] c_val;
    logic        z_val;

    assign a_val = regs_reg[msm_pkg::R_H];

    always_comb
    begin
        b_val = b_hold_reg;  // unknown source keeps the last B value
        case (bsrc)
            msm_pkg::B_MDR:  b_val = regs_reg[msm_pkg::R_MDR];
            msm_pkg::B_PC:   b_val = regs_reg[msm_pkg::R_PC];
            msm_pkg::B_MBRU: b_val = {24'd0, mbr_reg};
            msm_pkg::B_MBR:  b_val = {{24{mbr_reg[7]}}, mbr_reg};
            msm_pkg::B_SP:   b_val = regs_reg[msm_pkg::R_SP];
            msm_pkg::B_LV:   b_val = regs_reg[msm_pkg::R_LV];
            msm_pkg::B_CPP:  b_val = regs_reg[msm_pkg::R_CPP];
            msm_pkg::B_TOS:  b_val = regs_reg[msm_pkg::R_TOS];
            msm_pkg::B_OPC:  b_val = regs_reg[msm_pkg::R_OPC];
            default:         b_val = b_hold_reg;
        endcase
    end

    always_comb
    begin
        alu_out = c_hold_reg;  // unknown function keeps the last C value
        case (alu_fn)
            msm_pkg::ALU_AND:    alu_out = a_val & b_val;
            msm_pkg::ALU_ZERO:   alu_out = 32'd0;
            msm_pkg::ALU_B:      alu_out = b_val;
            msm_pkg::ALU_A:      alu_out = a_val;
            msm_pkg::ALU_NOTA:   alu_out = ~a_val;
            msm_pkg::ALU_OR:     alu_out = a_val | b_val;
            msm_pkg::ALU_NOTB:   alu_out = ~b_val;
            msm_pkg::ALU_ONE:    alu_out = 32'd1;
            msm_pkg::ALU_ONES:   alu_out = 32'hFFFF_FFFF;
            msm_pkg::ALU_BINC:   alu_out = b_val + 32'd1;
            msm_pkg::ALU_BDEC:   alu_out = b_val - 32'd1;
            msm_pkg::ALU_AINC:   alu_out = a_val + 32'd1;
            msm_pkg::ALU_NEGA:   alu_out = 32'd0 - a_val;
            msm_pkg::ALU_ADD:    alu_out = a_val + b_val;
            msm_pkg::ALU_ADDINC: alu_out = a_val + b_val + 32'd1;
            msm_pkg::ALU_BSUBA:  alu_out = b_val - a_val;
            default:             alu_out = c_hold_reg;
        endcase
    end

    // flags come from the unshifted result
    assign z_val = (alu_out == 32'd0);
    assign sll8  = {alu_out[23:0], 8'd0};

    always_comb
    begin
        c_val = alu_out;
        case (shift)
            msm_pkg::SH_NONE: c_val = alu_out;
            msm_pkg::SH_SRA1: c_val = {alu_out[31], alu_out[31:1]};
            msm_pkg::SH_SLL8: c_val = sll8;
            msm_pkg::SH_BOTH: c_val = {sll8[31], sll8[31:1]};
            default:          c_val = alu_out;
        endcase
    end

    // register file after the C bus write; a word read overwrites MDR later
    always_comb
    begin
        for (int r = 0; r < msm_pkg::NUM_REGS; r++)
        begin
            regs_next[r] = regs_reg[r];
            if (exec && wmask[r])
            begin
                regs_next[r] = c_val;
            end
        end
        if (s2_adv && (s2_reg.rd == msm_pkg::RD_WORD))
        begin
            regs_next[msm_pkg::R_MDR] = ram_rdata;
        end
    end

    // ------------------------------------------------------------------
    // Memory access, issued with the freshly written MAR/PC/MDR
    // ------------------------------------------------------------------
    logic                      ram_en;
    logic [3:0]                ram_we;
    logic [msm_pkg::ROW_W-1:0] ram_row;
    logic [31:0]               ram_wdata;
    logic [31:0]               load_addr;
    logic [31:0]               pc_new;
    logic [31:0]               mar_new;
    logic [31:0]               mdr_new;

    assign load_addr = {16'd0, cmd.load_address};
    assign pc_new    = exec && wmask[msm_pkg::R_PC]  ? c_val : regs_reg[msm_pkg::R_PC];
    assign mar_new   = exec && wmask[msm_pkg::R_MAR] ? c_val : regs_reg[msm_pkg::R_MAR];
    assign mdr_new   = exec && wmask[msm_pkg::R_MDR] ? c_val : regs_reg[msm_pkg::R_MDR];

    always_comb
    begin
        ram_en    = 1'b0;
        ram_we    = 4'd0;
        ram_row   = mar_new[msm_pkg::ROW_W-1:0];  // word base is MAR*4
        ram_wdata = mdr_new;
        if (accept && (cmd.opcode == msm_pkg::OP_LOAD))
        begin
            ram_en    = 1'b1;
            ram_we    = 4'd1 << load_addr[1:0];
            ram_row   = load_addr[msm_pkg::ADDR_W-1:2];
            ram_wdata = {4{cmd.load_byte}};
        end
        else if (exec)
        begin
            case (mem_op)
                msm_pkg::MEM_FETCH:
                begin
                    ram_en  = 1'b1;
                    ram_row = pc_new[msm_pkg::ADDR_W-1:2];
                end
                msm_pkg::MEM_READ:
                begin
                    ram_en = 1'b1;
                end
                msm_pkg::MEM_WRITE:
                begin
                    ram_en = 1'b1;
                    ram_we = 4'hF;
                end
                default:
                begin
                    ram_en = 1'b0;
                end
            endcase
        end
    end

    msm_ram u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .row   (ram_row),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Snapshot for the completion stage
    // ------------------------------------------------------------------
    always_comb
    begin
        s2_next.rd   = msm_pkg::RD_NONE;
        s2_next.lane = pc_new[1:0];
        s2_next.jam  = msm_pkg::JAM_KEEP;   // load items leave the counter alone
        s2_next.nxt  = nxt;
        s2_next.z    = flag_z_reg;
        s2_next.nz   = flag_nz_reg;
        s2_next.c    = c_hold_reg;
        s2_next.tos  = regs_reg[msm_pkg::R_TOS];
        if (exec)
        begin
            if (mem_op == msm_pkg::MEM_FETCH)
            begin
                s2_next.rd = msm_pkg::RD_FETCH;
            end
            else if (mem_op == msm_pkg::MEM_READ)
            begin
                s2_next.rd = msm_pkg::RD_WORD;
            end
            s2_next.jam = jam;
            s2_next.z   = z_val;
            s2_next.nz  = !z_val;
            s2_next.c   = c_val;
            s2_next.tos = regs_next[msm_pkg::R_TOS];
        end
    end

    // ------------------------------------------------------------------
    // Completion stage: land read data, resolve the next microaddress
    // ------------------------------------------------------------------
    always_comb
    begin
        mbr_next = mbr_reg;
        if (s2_reg.rd == msm_pkg::RD_FETCH)
        begin
            mbr_next = ram_rdata[8*s2_reg.lane +: 8];
        end
    end

    always_comb
    begin
        counter_next = counter_reg;
        case (s2_reg.jam)
            msm_pkg::JAM_NONE: counter_next = s2_reg.nxt;
            msm_pkg::JAM_Z:    counter_next = s2_reg.nxt | {s2_reg.z, 8'd0};
            msm_pkg::JAM_NZ:   counter_next = s2_reg.nxt | {s2_reg.nz, 8'd0};
            msm_pkg::JAM_MBR:  counter_next = s2_reg.nxt | {1'b0, mbr_next};
            default:           counter_next = counter_reg;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < msm_pkg::NUM_REGS; r++)
            begin
                regs_reg[r] <= 32'd0;
            end
            b_hold_reg    <= 32'd0;
            c_hold_reg    <= 32'd0;
            flag_z_reg    <= 1'b0;
            flag_nz_reg   <= 1'b0;
            mbr_reg       <= 8'd0;
            counter_reg   <= 9'd0;
            s2_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            for (int r = 0; r < msm_pkg::NUM_REGS; r++)
            begin
                regs_reg[r] <= regs_next[r];
            end
            if (exec)
            begin
                b_hold_reg  <= b_val;
                c_hold_reg  <= c_val;
                flag_z_reg  <= z_val;
                flag_nz_reg <= !z_val;
            end
            if (s2_adv)
            begin
                mbr_reg     <= mbr_next;
                counter_reg <= counter_next;
            end
            if (accept)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_adv)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_reg <= s2_next;
        end
        if (s2_adv)
        begin
            rsp_reg.next_address <= counter_next;
            rsp_reg.c_bus        <= s2_reg.c;
            rsp_reg.zero_flag    <= s2_reg.z;
            rsp_reg.nonzero_flag <= s2_reg.nz;
            rsp_reg.fetched_byte <= mbr_next;
            rsp_reg.top_of_stack <= s2_reg.tos;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    // a new result only ever comes from a completing second stage
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(s2_valid_reg))
        else $error("result appeared without a completing item");

    // a word read lands the memory row in MDR
    a_mdr_load: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_adv && (s2_reg.rd == msm_pkg::RD_WORD))
        |=> (regs_reg[msm_pkg::R_MDR] == $past(ram_rdata)))
        else $error("MDR does not hold the word read");

    // MBR moves only on a completing fetch
    a_mbr_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !(s2_adv && (s2_reg.rd == msm_pkg::RD_FETCH)) |=> $stable(mbr_reg))
        else $error("MBR changed without a fetch");
`endif

endmodule

[rtl/msm_ram.sv]
// ----------------------------------------------------------------------------
// msm_ram
// Main memory: four byte lanes sharing one row address, byte write enables,
// registered read data.
// ----------------------------------------------------------------------------
module msm_ram (
    input  logic                       clk,
    input  logic                       en,
    input  logic [3:0]                 we,
    input  logic [msm_pkg::ROW_W-1:0]  row,
    input  logic [31:0]                wdata,
    output logic [31:0]                rdata
);

    for (genvar i = 0; i < 4; i++)
    begin : g_lane
        logic [7:0] mem [msm_pkg::MEM_ROWS];
        logic [7:0] rdata_reg;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (we[i])
                begin
                    mem[row] <= wdata[8*i +: 8];
                end
                rdata_reg <= mem[row];
            end
        end

        assign rdata[8*i +: 8] = rdata_reg;
    end

endmodule
